// ----- design/swm_pkg.sv -----
// Shared constants and types for the sliding window maximum unit.
`timescale 1ns / 1ps

package swm_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int SAMPLE_W   = 32;
   localparam int CFG_W      = 7;
   localparam int AGE_W      = $clog2(WINDOW_MAX + 1);

   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WINDOW_MAX);

   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] value;
      logic [AGE_W-1:0]           age;
   } entry_type;

   typedef struct packed {
      logic                       load;
      logic                       shift;
      logic                       clear;
      logic signed [SAMPLE_W-1:0] sample;
   } cell_ctrl_type;

endpackage

// ----- design/swm_cell.sv -----
// One deque cell: holds an entry, ages it, pops it and takes its neighbor's entry on a shift.
`timescale 1ns / 1ps

module swm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  swm_pkg::cell_ctrl_type ctrl,
   input  swm_pkg::entry_type    upper_entry,
   input  logic                  lower_keep,
   output logic                  keep,
   output swm_pkg::entry_type    entry
);
   import swm_pkg::*;

   logic                       valid_ff;
   logic                       valid_in;
   logic signed [SAMPLE_W-1:0] value_ff;
   logic signed [SAMPLE_W-1:0] value_in;
   logic [AGE_W-1:0]           age_ff;
   logic [AGE_W-1:0]           age_in;
   entry_type                  own_entry;
   entry_type                  shifted;
   logic [AGE_W-1:0]           aged;

   assign own_entry = '{valid: valid_ff, value: value_ff, age: age_ff};
   assign entry     = own_entry;
   assign shifted   = ctrl.shift ? upper_entry : own_entry;
   assign aged      = (shifted.age == AGE_MAX) ? AGE_MAX : shifted.age + AGE_W'(1);
   assign keep      = shifted.valid && !ctrl.clear && !(shifted.value < ctrl.sample);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      age_in   = age_ff;
      if (ctrl.load) begin
         if (keep) begin
            valid_in = 1'b1;
            value_in = shifted.value;
            age_in   = aged;
         end else if (lower_keep) begin
            valid_in = 1'b1;
            value_in = ctrl.sample;
            age_in   = '0;
         end else begin
            valid_in = 1'b0;
         end
      end else if (ctrl.shift) begin
         valid_in = shifted.valid;
         value_in = shifted.value;
         age_in   = shifted.age;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff   <= age_in;
   end

endmodule

// ----- design/sliding_window_maximum_unit.sv -----
// Top level of the sliding window maximum unit: a chain of deque cells and its control.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         valid / stall      sample_value, first_of_sequence
//   rsp_      out        valid / stall      window_max
//   csr_      in         valid / ready      window_len
//
// One item is taken per cycle while the input is not stalled; the front result goes to the
// output register in the same cycle once the window has filled. After the window is shortened,
// each surplus aged entry is shifted out of the cell chain before the next item is taken.
// Reset empties the deque, clears the sample count and sets the window to one sample.
// The input stalls while the output register holds a stalled item or aged entries are purged.
`timescale 1ns / 1ps

module sliding_window_maximum_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic                           req_first_of_sequence,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [swm_pkg::SAMPLE_W-1:0] rsp_window_max,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [swm_pkg::CFG_W-1:0]      csr_window_len
);
   import swm_pkg::*;

   logic [CFG_W-1:0]           window_len_ff;
   logic [CFG_W-1:0]           window_len_in;
   logic [AGE_W-1:0]           seen_ff;
   logic [AGE_W-1:0]           seen_in;
   logic [AGE_W-1:0]           seen_base;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_max_ff;
   logic signed [SAMPLE_W-1:0] rsp_max_in;

   logic [AGE_W-1:0]           win_eff;
   logic [AGE_W-1:0]           win_m1;
   logic                       retire_front;
   logic                       need_purge;
   logic                       purge;
   logic                       out_free;
   logic                       accept;
   logic                       emit;
   entry_type                  front_shifted;
   logic signed [SAMPLE_W-1:0] front_next;
   cell_ctrl_type              ctrl;

   entry_type                  cell_entry [WINDOW_MAX];
   entry_type                  cell_upper [WINDOW_MAX];
   logic                       cell_keep  [WINDOW_MAX];
   logic                       cell_lower [WINDOW_MAX];

   always_comb begin
      if (window_len_ff == '0) begin
         win_eff = AGE_W'(1);
      end else if (window_len_ff > CFG_W'(WINDOW_MAX)) begin
         win_eff = AGE_MAX;
      end else begin
         win_eff = AGE_W'(window_len_ff);
      end
   end

   assign win_m1       = win_eff - AGE_W'(1);
   assign retire_front = cell_entry[0].valid && (cell_entry[0].age >= win_m1);
   assign need_purge   = cell_entry[1].valid && (cell_entry[1].age >= win_m1);
   assign purge        = req_valid && need_purge;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = need_purge || !out_free;
   assign accept       = req_valid && !req_stall;
   assign csr_ready    = !purge;

   assign ctrl.load   = accept;
   assign ctrl.shift  = purge || (accept && retire_front);
   assign ctrl.clear  = req_first_of_sequence;
   assign ctrl.sample = req_sample_value;

   for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
      if (k == WINDOW_MAX - 1) begin : g_top
         assign cell_upper[k] = '{valid: 1'b0, value: '0, age: '0};
      end else begin : g_mid
         assign cell_upper[k] = cell_entry[k+1];
      end
      if (k == 0) begin : g_front
         assign cell_lower[k] = 1'b1;
      end else begin : g_rest
         assign cell_lower[k] = cell_keep[k-1];
      end
      swm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .upper_entry (cell_upper[k]),
         .lower_keep  (cell_lower[k]),
         .keep        (cell_keep[k]),
         .entry       (cell_entry[k])
      );
   end

   assign front_shifted = retire_front ? cell_upper[0] : cell_entry[0];
   assign front_next    = cell_keep[0] ? front_shifted.value : req_sample_value;

   assign seen_base = req_first_of_sequence ? '0 : seen_ff;
   assign emit      = (((seen_base == AGE_MAX) ? AGE_MAX : seen_base + AGE_W'(1)) >= win_eff);

   always_comb begin
      window_len_in = window_len_ff;
      seen_in       = seen_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_max_in    = rsp_max_ff;
      if (csr_valid && csr_ready) begin
         window_len_in = csr_window_len;
      end
      if (accept) begin
         seen_in      = (seen_base == AGE_MAX) ? AGE_MAX : seen_base + AGE_W'(1);
         rsp_valid_in = emit;
         if (emit) begin
            rsp_max_in = front_next;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= CFG_W'(1);
         seen_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         window_len_ff <= window_len_in;
         seen_ff       <= seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_max_ff <= rsp_max_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_max_ff;

endmodule

// ----- verif/sliding_window_maximum_unit_test.sv -----
// Self-checking testbench for the sliding window maximum unit with a deque scoreboard.
`timescale 1ns / 1ps

module sliding_window_maximum_unit_test;
   import swm_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 500000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned RANDOM_ITEMS    = 1700;
   localparam int unsigned EXPECT_DEPTH    = 64;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

   class window_max_scoreboard;
      logic [CFG_W-1:0]           window_len;
      logic signed [SAMPLE_W-1:0] held_value [WINDOW_MAX];
      int unsigned                held_age [WINDOW_MAX];
      int unsigned                held_count;
      int unsigned                samples_seen;
      logic signed [SAMPLE_W-1:0] expected_max [EXPECT_DEPTH];
      int unsigned                expect_rd;
      int unsigned                expect_wr;
      int unsigned                failures;

      function new();
         window_len   = CFG_W'(1);
         held_count   = 0;
         samples_seen = 0;
         expect_rd    = 0;
         expect_wr    = 0;
         failures     = 0;
      endfunction

      function int unsigned pending();
         return expect_wr - expect_rd;
      endfunction

      // Removes the given number of entries from the head of the deque.
      function void drop_head(int unsigned count);
         for (int unsigned k = 0; k + count < held_count; k++) begin
            held_value[k] = held_value[k + count];
            held_age[k]   = held_age[k + count];
         end
         held_count -= count;
      endfunction

      // Updates the deque for one accepted item and queues the window maximum it yields.
      function void note_sample(logic signed [SAMPLE_W-1:0] value, logic first);
         int unsigned span;
         int unsigned drop;
         span = (window_len == 0) ? 1 :
                (window_len > WINDOW_MAX) ? WINDOW_MAX : window_len;
         if (first) begin
            held_count   = 0;
            samples_seen = 0;
         end
         for (int unsigned k = 0; k < held_count; k++) begin
            if (held_age[k] < WINDOW_MAX) held_age[k]++;
         end
         drop = 0;
         while (drop < held_count && held_age[drop] >= span) drop++;
         if (drop > 0) drop_head(drop);
         while (held_count > 0 && held_value[held_count - 1] < value) held_count--;
         if (held_count >= WINDOW_MAX) drop_head(1);
         held_value[held_count] = value;
         held_age[held_count]   = 0;
         held_count++;
         if (samples_seen < WINDOW_MAX) samples_seen++;
         if (samples_seen >= span) begin
            if (pending() >= EXPECT_DEPTH) begin
               $error("window_max: too many results outstanding, expected %0d dropped",
                      held_value[0]);
               failures++;
            end else begin
               expected_max[expect_wr % EXPECT_DEPTH] = held_value[0];
               expect_wr++;
            end
         end
      endfunction

      function void check_result(logic signed [SAMPLE_W-1:0] actual);
         logic signed [SAMPLE_W-1:0] wanted;
         if (pending() == 0) begin
            $error("window_max: no result expected, actual %0d", actual);
            failures++;
         end else begin
            wanted = expected_max[expect_rd % EXPECT_DEPTH];
            expect_rd++;
            if (actual !== wanted) begin
               $error("window_max mismatch: expected %0d, actual %0d", wanted, actual);
               failures++;
            end
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_value;
   logic                       req_first_of_sequence;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_window_max;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CFG_W-1:0]           csr_window_len;

   logic                       steady = 1'b0;
   logic                       hold_off_request = 1'b0;
   int unsigned                cycle_count = 0;
   window_max_scoreboard       sb;

   sliding_window_maximum_unit i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sample_value      (req_sample_value),
      .req_first_of_sequence (req_first_of_sequence),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_window_max        (rsp_window_max),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_window_len        (csr_window_len)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic first);
      if (!steady) begin
         while ($urandom_range(0, 99) < 28) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid             <= 1'b1;
      req_sample_value      <= value;
      req_first_of_sequence <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_sample(value, first);
   endtask

   task automatic write_window(input logic [CFG_W-1:0] len);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_window_len <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.window_len = len;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_window_max);
   end

   initial begin : receiver
      int unsigned held;
      bit          hold_done;
      held      = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && !hold_done) begin
            held      = HOLD_OFF_CYCLES;
            hold_done = 1'b1;
         end
         if (held > 0) begin
            held--;
            rsp_stall <= 1'b1;
         end else if (steady) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 28);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL sliding_window_maximum_unit");
      $finish;
   end

   initial begin : stimulus
      int unsigned                sent;
      int unsigned                phase;
      int unsigned                length;
      int unsigned                mode;
      int unsigned                k;
      int                         offset;
      logic [CFG_W-1:0]           len;
      logic signed [SAMPLE_W-1:0] value;
      logic                       first;

      sb                    = new();
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_sample_value      = '0;
      req_first_of_sequence = 1'b0;
      csr_valid             = 1'b0;
      csr_window_len        = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The window is one sample long out of reset.
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(0, 1'b0);
      send_sample(-1, 1'b0);

      // Warm-up, equal values kept, extremes, and a new sequence mid-stream.
      write_window(CFG_W'(3));
      send_sample(5, 1'b1);
      send_sample(5, 1'b0);
      send_sample(5, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(9, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(-1, 1'b1);
      send_sample(-1, 1'b0);
      send_sample(-1, 1'b0);

      // A full descending deque, then a shorter window retires several entries before the next sample.
      write_window(CFG_W'(6));
      for (k = 0; k < 6; k++) send_sample(60 - 10 * k, k == 0);
      write_window(CFG_W'(2));
      send_sample(0, 1'b0);

      // Zero acts as one sample; an oversized window acts as the largest one.
      write_window(CFG_W'(0));
      send_sample(3, 1'b0);
      write_window(CFG_W'(127));
      send_sample(4, 1'b0);

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       len = CFG_W'(0);
            1:       len = CFG_W'(1);
            2:       len = CFG_W'(64);
            3:       len = CFG_W'($urandom_range(65, 127));
            4:       len = CFG_W'(127);
            5, 6:    len = CFG_W'($urandom_range(2, 8));
            default: len = CFG_W'($urandom_range(1, 64));
         endcase
         length = $urandom_range(40, 120);
         mode   = $urandom_range(0, 4);
         if (phase == 3) begin
            len    = CFG_W'(64);
            mode   = 2;
            length = 150;
         end
         write_window(len);
         steady = (phase == 2);
         if (phase == 4) hold_off_request = 1'b1;
         value = $urandom;
         for (k = 0; k < length; k++) begin
            if (k == 0) first = (phase == 3) || ($urandom_range(0, 9) < 6);
            else first = ($urandom_range(0, 49) == 0);
            case (mode)
               0: value = $urandom;
               1: begin
                  offset = $urandom_range(0, 7);
                  value  = offset - 4;
               end
               2: value = value - $urandom_range(0, 3);
               3: value = value + $urandom_range(0, 3);
               default: begin
                  case ($urandom_range(0, 4))
                     0:       value = SAMPLE_MIN;
                     1:       value = SAMPLE_MAX;
                     2:       value = 0;
                     3:       value = -1;
                     default: value = $urandom;
                  endcase
               end
            endcase
            send_sample(value, first);
         end
         sent += length;
         phase++;
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.failures == 0) begin
         $display("PASS sliding_window_maximum_unit");
      end else begin
         $display("FAIL sliding_window_maximum_unit");
      end
      $finish;
   end

endmodule

// ----- sliding_window_maximum_unit.f -----
design/swm_pkg.sv
design/swm_cell.sv
design/sliding_window_maximum_unit.sv
verif/sliding_window_maximum_unit_test.sv
